// ===== design/psrl_pkg.sv =====
// Shared types, codes and constants of the PWM setpoint ramp limiter.
`default_nettype none

package psrl_pkg;

    localparam int PWM_WIDTH = 16;
    localparam int SUM_W     = PWM_WIDTH + 2;
    localparam int MAG_W     = 8;
    localparam int SPAN_W    = 16;
    localparam int PROD_W    = MAG_W + SPAN_W;
    localparam int DIV_CNT_W = $clog2(PROD_W);
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = 40;

    typedef logic [PWM_WIDTH-1:0] t_pwm;
    typedef logic [PROD_W-1:0]    t_prod;

    localparam t_pwm PWM_MAX = {PWM_WIDTH{1'b1}};
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PROD_W - 1);

    localparam logic [MAG_W-1:0] REVERSE_LIMIT = 8'h80;
    localparam logic [MAG_W-1:0] BYTE_MASK     = 8'hff;

    // Input kinds
    localparam logic [2:0] MODE_SPEED   = 3'd0;
    localparam logic [2:0] MODE_TICK    = 3'd1;
    localparam logic [2:0] MODE_BRAKE   = 3'd2;
    localparam logic [2:0] MODE_ENABLE  = 3'd3;
    localparam logic [2:0] MODE_DISABLE = 3'd4;

    // Register indexes
    localparam logic [2:0] CFG_STYLE = 3'd0;
    localparam logic [2:0] CFG_BASE  = 3'd1;
    localparam logic [2:0] CFG_SPAN  = 3'd2;
    localparam logic [2:0] CFG_STEP  = 3'd3;
    localparam logic [2:0] CFG_VMAX  = 3'd4;

    // Reset values
    localparam logic [15:0] RST_BASE = 16'd1500;
    localparam logic [15:0] RST_SPAN = 16'd300;
    localparam logic [7:0]  RST_STEP = 8'd10;
    localparam logic [7:0]  RST_VMAX = 8'd128;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV,
        ST_TGT,
        ST_RAMP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [PROD_W-1:0]    dividend;
        logic [MAG_W-1:0]     divisor;
    } t_div_req;

endpackage

`default_nettype wire

// ===== design/psrl_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module psrl_div (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire psrl_pkg::t_div_req         i_req,
    output logic                            o_done,
    output logic [psrl_pkg::PROD_W-1:0]     o_quotient
);

    logic                              r_busy;
    logic                              r_done;
    logic [psrl_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [psrl_pkg::MAG_W-1:0]        r_rem;
    logic [psrl_pkg::PROD_W-1:0]       r_quo;
    logic [psrl_pkg::MAG_W-1:0]        r_div;

    logic [psrl_pkg::MAG_W:0]          w_trial;
    logic                              w_fit;

    assign w_trial = {r_rem, r_quo[psrl_pkg::PROD_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == psrl_pkg::DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            // shift in next dividend bit, subtract where it fits
            r_rem <= w_fit ? psrl_pkg::MAG_W'(w_trial - {1'b0, r_div})
                           : w_trial[psrl_pkg::MAG_W-1:0];
            r_quo <= {r_quo[psrl_pkg::PROD_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== design/pwm_setpoint_ramp_limiter.sv =====
// Top level of the PWM setpoint ramp limiter: decoder, sequencer, ramp and output register.
`default_nettype none

// Channel   | Direction | Handshake                     | Payload
// ----------+-----------+-------------------------------+------------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready | tuser: mode, tdata: speed_code
// m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata: pwm_value, reverse, drive_on,
//           |           |                               |        fault_count
// cfg       | in        | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// An update tick with drive on passes from acceptance through the product, the divider
// launch, the serial divider (one quotient bit at a time) and its done flag, then target,
// ramp and output load. Every other word goes from acceptance straight to the output load,
// and the next word can be taken once that load is done.
// Input is not ready while a word is in progress; a finished result waits in the output
// register, and the next word is taken while it waits. A stalled output only holds back
// the load of the following result.
// Reset is synchronous, active low; it restores state and settings, not data registers.

module pwm_setpoint_ramp_limiter (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] speed_code
    input  wire  [2:0]  s_axis_tuser,   // [2:0] mode
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] pwm_value, [16] reverse, [17] drive_on,
                                        // [33:18] fault_count, [39:34] zero
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);

    localparam int SW = psrl_pkg::SUM_W;
    localparam int PW = psrl_pkg::PWM_WIDTH;

    // configuration registers
    logic                           r_style;
    logic [psrl_pkg::SPAN_W-1:0]    r_base;
    logic [psrl_pkg::SPAN_W-1:0]    r_span;
    logic [psrl_pkg::MAG_W-1:0]     r_step;
    logic [psrl_pkg::MAG_W-1:0]     r_vmax;

    // block state
    psrl_pkg::t_state               r_state, n_state;
    logic [psrl_pkg::MAG_W-1:0]     r_mag, n_mag;
    logic                           r_dir, n_dir;
    logic                           r_enabled, n_enabled;
    logic                           r_braking, n_braking;
    psrl_pkg::t_pwm                 r_pwm_now, n_pwm_now;
    psrl_pkg::t_pwm                 r_target, n_target;
    logic [15:0]                    r_faults, n_faults;

    // work registers of the tick path
    psrl_pkg::t_prod                r_prod;
    logic [psrl_pkg::SPAN_W-1:0]    r_scaled, n_scaled;

    // output register
    logic                           r_out_valid, n_out_valid;
    logic [psrl_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    psrl_pkg::t_div_req             w_div_req;
    logic                           w_div_done;
    logic [psrl_pkg::PROD_W-1:0]    w_quotient;

    logic                           w_accept;
    logic                           w_drive_on;
    logic [SW-1:0]                  w_now, w_base, w_step, w_scaled, w_tgt;
    psrl_pkg::t_pwm                 w_base_clamped;
    psrl_pkg::t_pwm                 w_brake_val;
    psrl_pkg::t_pwm                 w_tgt_val;
    logic [psrl_pkg::MAG_W-1:0]     w_code;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == psrl_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_drive_on    = r_enabled && !r_braking;
    assign w_code        = s_axis_tdata;

    assign w_now    = SW'(r_pwm_now);
    assign w_base   = SW'(r_base);
    assign w_step   = SW'(r_step);
    assign w_scaled = SW'(r_scaled);
    assign w_tgt    = SW'(r_target);

    assign w_base_clamped = (w_base > SW'(psrl_pkg::PWM_MAX)) ? psrl_pkg::PWM_MAX
                                                             : PW'(r_base);

    // brake step toward base
    always_comb begin
        if (!r_style) begin
            if (w_now > w_base + w_step) begin
                w_brake_val = PW'(w_now - w_step);
            end else if (w_base > w_now + w_step) begin
                w_brake_val = PW'(w_now + w_step);
            end else begin
                w_brake_val = w_base_clamped;
            end
        end else begin
            if (w_now >= w_base + w_step) begin
                w_brake_val = PW'(w_now - w_step);
            end else begin
                w_brake_val = w_base_clamped;
            end
        end
    end

    // target from scaled magnitude, saturated at both ends of the range
    always_comb begin
        if (!r_style && r_dir) begin
            w_tgt_val = (w_base >= w_scaled) ? PW'(w_base - w_scaled) : '0;
        end else if (w_base + w_scaled > SW'(psrl_pkg::PWM_MAX)) begin
            w_tgt_val = psrl_pkg::PWM_MAX;
        end else begin
            w_tgt_val = PW'(w_base + w_scaled);
        end
    end

    always_comb begin
        w_div_req.start    = (r_state == psrl_pkg::ST_DIV_GO);
        w_div_req.dividend = r_prod;
        w_div_req.divisor  = r_vmax;
    end

    psrl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // sequencer: next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_dir       = r_dir;
        n_enabled   = r_enabled;
        n_braking   = r_braking;
        n_pwm_now   = r_pwm_now;
        n_target    = r_target;
        n_faults    = r_faults;
        n_scaled    = r_scaled;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;

        case (r_state)
            psrl_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = psrl_pkg::ST_EMIT;
                    case (s_axis_tuser)
                        psrl_pkg::MODE_SPEED: begin
                            if (w_code > psrl_pkg::REVERSE_LIMIT) begin
                                n_mag = psrl_pkg::MAG_W'(psrl_pkg::BYTE_MASK - w_code + 8'd1);
                                n_dir = 1'b1;
                            end else begin
                                n_mag = w_code;
                                n_dir = 1'b0;
                            end
                            if (w_code == '0) begin
                                n_braking = 1'b0;
                            end
                        end
                        psrl_pkg::MODE_TICK: begin
                            if (w_drive_on) begin
                                n_state = psrl_pkg::ST_MUL;
                            end else begin
                                // snap to base, target untouched
                                n_pwm_now = w_base_clamped;
                            end
                        end
                        psrl_pkg::MODE_BRAKE: begin
                            n_pwm_now = w_brake_val;
                        end
                        psrl_pkg::MODE_ENABLE: begin
                            n_enabled = 1'b1;
                        end
                        psrl_pkg::MODE_DISABLE: begin
                            n_enabled = 1'b0;
                            n_braking = 1'b1;
                            n_faults  = r_faults + 16'd1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            psrl_pkg::ST_MUL: begin
                n_state = psrl_pkg::ST_DIV_GO;
            end
            psrl_pkg::ST_DIV_GO: begin
                n_state = psrl_pkg::ST_DIV;
            end
            psrl_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = psrl_pkg::ST_TGT;
                    // zero magnitude gives zero even when vel_max is zero
                    if (r_mag == '0) begin
                        n_scaled = '0;
                    end else if (w_quotient > psrl_pkg::PROD_W'(r_span)) begin
                        n_scaled = r_span;
                    end else begin
                        n_scaled = w_quotient[psrl_pkg::SPAN_W-1:0];
                    end
                end
            end
            psrl_pkg::ST_TGT: begin
                n_target = w_tgt_val;
                n_state  = psrl_pkg::ST_RAMP;
            end
            psrl_pkg::ST_RAMP: begin
                // move by at most one step toward the target
                if (w_tgt > w_now + w_step) begin
                    n_pwm_now = PW'(w_now + w_step);
                end else if (w_now > w_tgt + w_step) begin
                    n_pwm_now = PW'(w_now - w_step);
                end else begin
                    n_pwm_now = r_target;
                end
                n_state = psrl_pkg::ST_EMIT;
            end
            psrl_pkg::ST_EMIT: begin
                // load the word once the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {6'b0, r_faults, w_drive_on, r_dir, 16'(r_pwm_now)};
                    n_state     = psrl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = psrl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psrl_pkg::ST_IDLE;
            r_mag       <= '0;
            r_dir       <= 1'b0;
            r_enabled   <= 1'b0;
            r_braking   <= 1'b0;
            r_pwm_now   <= PW'(psrl_pkg::RST_BASE);
            r_target    <= PW'(psrl_pkg::RST_BASE);
            r_faults    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mag       <= n_mag;
            r_dir       <= n_dir;
            r_enabled   <= n_enabled;
            r_braking   <= n_braking;
            r_pwm_now   <= n_pwm_now;
            r_target    <= n_target;
            r_faults    <= n_faults;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers of the tick path and output
    always_ff @(posedge i_clk) begin
        r_scaled   <= n_scaled;
        r_out_data <= n_out_data;
        if (r_state == psrl_pkg::ST_MUL) begin
            r_prod <= psrl_pkg::PROD_W'(r_mag) * psrl_pkg::PROD_W'(r_span);
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_style <= 1'b0;
            r_base  <= psrl_pkg::RST_BASE;
            r_span  <= psrl_pkg::RST_SPAN;
            r_step  <= psrl_pkg::RST_STEP;
            r_vmax  <= psrl_pkg::RST_VMAX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                psrl_pkg::CFG_STYLE: r_style <= i_cfg_data[0];
                psrl_pkg::CFG_BASE:  r_base  <= i_cfg_data;
                psrl_pkg::CFG_SPAN:  r_span  <= i_cfg_data;
                psrl_pkg::CFG_STEP:  r_step  <= i_cfg_data[7:0];
                psrl_pkg::CFG_VMAX:  r_vmax  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // the divider only reports completion while the sequencer waits for it
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == psrl_pkg::ST_DIV))
        else $error("divider done outside wait state");

    // a tick with drive off snaps the output to base
    a_tick_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (s_axis_tuser == psrl_pkg::MODE_TICK) && !w_drive_on)
        |=> (r_pwm_now == $past(w_base_clamped)))
        else $error("tick while off did not snap to base");

    // a new result word appears only from the load state
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && !(r_out_valid && !m_axis_tready))
        |-> (r_state == psrl_pkg::ST_EMIT))
        else $error("result word loaded outside load state");

endmodule

`default_nettype wire
